// ===== rtl/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// rycc_pkg - shared constants, types and helpers
// Sample and coefficient formats, BT.709 weights in fixed point, the stage
// bus types between the pipeline modules and the final round/saturate helper.
// ----------------------------------------------------------------------------
package rycc_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int COEF_FRAC_BITS = 16;

    // Coefficient word: Q2.COEF_FRAC_BITS plus a sign bit
    localparam int CF_W = COEF_FRAC_BITS + 3;
    // Front-end word: products and sums with COEF_FRAC_BITS fraction bits
    localparam int W1   = SAMPLE_BITS + COEF_FRAC_BITS + 3;
    // Back-end word: values with 2*COEF_FRAC_BITS fraction bits
    localparam int W3   = SAMPLE_BITS + 2 * COEF_FRAC_BITS + 4;
    // Stream data: three samples packed, padded to whole bytes
    localparam int TDATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

    typedef logic        [SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [SAMPLE_BITS:0]   t_opnd;
    typedef logic signed [CF_W-1:0]        t_coef;
    typedef logic signed [W1-1:0]          t_w1;
    typedef logic signed [W3-1:0]          t_w3;
    typedef logic signed [W3:0]            t_w3x;

    localparam t_opnd SMP_MID = t_opnd'(1 <<< (SAMPLE_BITS - 1));
    localparam t_smp  SMP_MAX = '1;

    // Forward weights, rounded to nearest from exact ratios
    localparam t_coef C_KR = t_coef'(((64'sd2126 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam t_coef C_KG = t_coef'(((64'sd7152 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam t_coef C_KB = t_coef'(((64'sd722 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam t_coef C_CB = t_coef'(((64'sd5000 <<< COEF_FRAC_BITS) + 64'sd4639) / 64'sd9278);
    localparam t_coef C_CR = t_coef'(((64'sd5000 <<< COEF_FRAC_BITS) + 64'sd3937) / 64'sd7874);
    // Reverse weights
    localparam t_coef C_RCR  = t_coef'(((64'sd15748 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam t_coef C_BCB  = t_coef'(((64'sd18556 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam t_coef C_INVG = t_coef'(((64'sd10000 <<< COEF_FRAC_BITS) + 64'sd3576) / 64'sd7152);
    localparam t_coef C_RG   = t_coef'(((64'sd2126 <<< COEF_FRAC_BITS) + 64'sd3576) / 64'sd7152);
    localparam t_coef C_BG   = t_coef'(((64'sd722 <<< COEF_FRAC_BITS) + 64'sd3576) / 64'sd7152);

    // Rounding constants for values carrying 2*COEF_FRAC_BITS fraction bits
    localparam t_w3x RND_HALF = t_w3x'(64'sd1 <<< (2 * COEF_FRAC_BITS - 1));
    localparam t_w3x RND_MID  = t_w3x'(64'sd1 <<< (SAMPLE_BITS - 1 + 2 * COEF_FRAC_BITS));

    // Bus from the front end (stage 2) to the back end
    typedef struct packed {
        logic vld;
        logic last;
        t_w1  v0;
        t_w1  v1;
        t_w1  v2;
    } t_s2_bus;

    // Bus from the back end (stage 4) to the output stage
    typedef struct packed {
        logic vld;
        logic last;
        t_w3  v0;
        t_w3  v1;
        t_w3  v2;
    } t_s4_bus;

    // Round to nearest (ties up), optionally add the chroma offset, saturate
    function automatic t_smp round_sat(input t_w3 v, input logic add_mid);
        t_w3x                          s;
        logic [W3-2*COEF_FRAC_BITS-1:0] hi;
        t_smp                          res;
        s  = t_w3x'(v) + RND_HALF + (add_mid ? RND_MID : t_w3x'(0));
        hi = s[W3-1:2*COEF_FRAC_BITS];
        if (s[W3]) begin
            res = '0;
        end else if (hi > (W3-2*COEF_FRAC_BITS)'(SMP_MAX)) begin
            res = SMP_MAX;
        end else begin
            res = hi[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/rycc_front.sv =====
// ----------------------------------------------------------------------------
// rycc_front - weighting and first sums (stages 1 and 2)
// Stage 1 forms three weighted samples, stage 2 adds them into Y (forward)
// or into R and B (reverse).
// ----------------------------------------------------------------------------
module rycc_front
    import rycc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_dir,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_smp    i_first,
    input  t_smp    i_second,
    input  t_smp    i_third,
    input  logic    i_last,
    output t_s2_bus o_bus,
    input  logic    i_ready
);

    t_opnd op0, op1, op2;
    t_coef cf0, cf1, cf2;
    t_w1   n_p0, n_p1, n_p2;
    t_w1   n_s0, n_s1, n_s2;

    logic  r_v1, r_v2;
    logic  r_l1, r_l2;
    t_w1   r_p0, r_p1, r_p2;
    t_smp  r_a, r_c;
    t_w1   r_s0, r_s1, r_s2;

    logic  st1_ready, st2_ready;

    assign st2_ready = !r_v2 || i_ready;
    assign st1_ready = !r_v1 || st2_ready;
    assign o_ready   = st1_ready;

    // Stage 1: one multiplier per lane, operands chosen by direction
    always_comb begin
        if (i_dir) begin
            op0 = t_opnd'(i_third) - SMP_MID;
            cf0 = C_RCR;
            op1 = t_opnd'(i_second) - SMP_MID;
            cf1 = C_BCB;
            op2 = t_opnd'(i_first);
            cf2 = C_INVG;
        end else begin
            op0 = t_opnd'(i_first);
            cf0 = C_KR;
            op1 = t_opnd'(i_second);
            cf1 = C_KG;
            op2 = t_opnd'(i_third);
            cf2 = C_KB;
        end
        n_p0 = t_w1'(cf0) * t_w1'(op0);
        n_p1 = t_w1'(cf1) * t_w1'(op1);
        n_p2 = t_w1'(cf2) * t_w1'(op2);
    end

    // Stage 2: forward sums Y; reverse adds the scaled Y to R and B
    always_comb begin
        if (i_dir) begin
            n_s0 = (t_w1'(r_a) <<< COEF_FRAC_BITS) + r_p0;
            n_s1 = (t_w1'(r_a) <<< COEF_FRAC_BITS) + r_p1;
            n_s2 = r_p2;
        end else begin
            n_s0 = r_p0 + r_p1 + r_p2;
            n_s1 = t_w1'(r_a);
            n_s2 = t_w1'(r_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (st1_ready) begin
                r_v1 <= i_valid;
            end
            if (st2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (st1_ready && i_valid) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_a  <= i_first;
            r_c  <= i_third;
            r_l1 <= i_last;
        end
        if (st2_ready && r_v1) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_l2 <= r_l1;
        end
    end

    assign o_bus.vld  = r_v2;
    assign o_bus.last = r_l2;
    assign o_bus.v0   = r_s0;
    assign o_bus.v1   = r_s1;
    assign o_bus.v2   = r_s2;

endmodule

// ===== rtl/rycc_back.sv =====
// ----------------------------------------------------------------------------
// rycc_back - differences and second weighting (stages 3 and 4)
// Forward: colour differences, then Cb/Cr scaling. Reverse: R and B weights,
// then G. All three lanes leave with 2*COEF_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module rycc_back
    import rycc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_dir,
    input  t_s2_bus i_bus,
    output logic    o_ready,
    output t_s4_bus o_bus,
    input  logic    i_ready
);

    t_w3  e0, e1, e2;
    t_w3  n_t0, n_t1, n_t2, n_t3, n_t4;
    t_w3  n_u0, n_u1, n_u2;

    logic r_v3, r_v4;
    logic r_l3, r_l4;
    t_w3  r_t0, r_t1, r_t2, r_t3, r_t4;
    t_w3  r_u0, r_u1, r_u2;

    logic st3_ready, st4_ready;

    assign st4_ready = !r_v4 || i_ready;
    assign st3_ready = !r_v3 || st4_ready;
    assign o_ready   = st3_ready;

    assign e0 = t_w3'(i_bus.v0);
    assign e1 = t_w3'(i_bus.v1);
    assign e2 = t_w3'(i_bus.v2);

    // Stage 3
    always_comb begin
        if (i_dir) begin
            n_t0 = e0;
            n_t1 = e1;
            n_t2 = e2;
            n_t3 = t_w3'(C_RG) * e0;
            n_t4 = t_w3'(C_BG) * e1;
        end else begin
            n_t0 = e0;
            n_t1 = (e2 <<< COEF_FRAC_BITS) - e0;
            n_t2 = (e1 <<< COEF_FRAC_BITS) - e0;
            n_t3 = '0;
            n_t4 = '0;
        end
    end

    // Stage 4
    always_comb begin
        if (i_dir) begin
            n_u0 = r_t0 <<< COEF_FRAC_BITS;
            n_u1 = (r_t2 <<< COEF_FRAC_BITS) - r_t3 - r_t4;
            n_u2 = r_t1 <<< COEF_FRAC_BITS;
        end else begin
            n_u0 = r_t0 <<< COEF_FRAC_BITS;
            n_u1 = t_w3'(C_CB) * r_t1;
            n_u2 = t_w3'(C_CR) * r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (st3_ready) begin
                r_v3 <= i_bus.vld;
            end
            if (st4_ready) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (st3_ready && i_bus.vld) begin
            r_t0 <= n_t0;
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_t4 <= n_t4;
            r_l3 <= i_bus.last;
        end
        if (st4_ready && r_v3) begin
            r_u0 <= n_u0;
            r_u1 <= n_u1;
            r_u2 <= n_u2;
            r_l4 <= r_l3;
        end
    end

    assign o_bus.vld  = r_v4;
    assign o_bus.last = r_l4;
    assign o_bus.v0   = r_u0;
    assign o_bus.v1   = r_u1;
    assign o_bus.v2   = r_u2;

endmodule

// ===== rtl/rycc_round.sv =====
// ----------------------------------------------------------------------------
// rycc_round - rounding, saturation and output register (stage 5)
// ----------------------------------------------------------------------------
module rycc_round
    import rycc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_dir,
    input  t_s4_bus i_bus,
    output logic    o_ready,
    output logic    o_valid,
    output t_smp    o_first,
    output t_smp    o_second,
    output t_smp    o_third,
    output logic    o_last,
    input  logic    i_ready
);

    logic r_vld;
    logic r_last;
    t_smp r_first, r_second, r_third;
    logic st5_ready;

    assign st5_ready = !r_vld || i_ready;
    assign o_ready   = st5_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (st5_ready) begin
            r_vld <= i_bus.vld;
        end
    end

    // Chroma lanes take the mid-scale offset in the forward direction only
    always_ff @(posedge i_clk) begin
        if (st5_ready && i_bus.vld) begin
            r_first  <= round_sat(i_bus.v0, 1'b0);
            r_second <= round_sat(i_bus.v1, !i_dir);
            r_third  <= round_sat(i_bus.v2, !i_dir);
            r_last   <= i_bus.last;
        end
    end

    assign o_valid  = r_vld;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_third  = r_third;
    assign o_last   = r_last;

endmodule

// ===== rtl/rgb_ycbcr_color_convert_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert_unit - BT.709 full-range RGB <-> YCbCr converter
// Five-stage pipe, one pixel per clock unless stalled, direction by register.
// ----------------------------------------------------------------------------
// Converts one 12-bit pixel per transfer between RGB and full-range YCbCr
// using BT.709 weights in Q2.16 fixed point. The direction register selects
// RGB to YCbCr (0, reset value) or YCbCr to RGB (1); write it only while no
// pixel is in flight. Every input transfer gives exactly one output transfer,
// and a new pixel can be taken on every clock while the output side is ready.
// The five register stages are: weighting multipliers, first sums,
// differences (or R/B weights), second weighting (or G sum), and rounding
// with saturation into the output register. Each stage holds its pixel
// while the stage after it is full and stalled, so a stalled output backs
// up through the pipe without losing or repeating a pixel. Final
// results are rounded to nearest (ties upward) and clamped to 0..4095;
// intermediate Y, R and B are not clamped. tlast travels with its pixel.
// ----------------------------------------------------------------------------
module rgb_ycbcr_color_convert_unit
    import rycc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Configuration: bit 0 is the direction
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,

    // Input pixel stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // tdata: first_in [11:0], second_in [23:12], third_in [35:24], zero pad
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    input  logic               i_s_axis_tlast,   // last_pixel_in

    // Output pixel stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // tdata: first_out [11:0], second_out [23:12], third_out [35:24], zero pad
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tlast    // last_pixel_out
);

    logic    r_direction;

    t_s2_bus s2_bus;
    t_s4_bus s4_bus;
    logic    back_ready;
    logic    round_ready;

    t_smp    out_first, out_second, out_third;

    // Direction register: always ready, so every write is taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_direction <= i_cfg_data;
        end
    end

    // Stages 1-2: weights and first sums
    rycc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_direction),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_first  (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_second (i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_third  (i_s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .i_last   (i_s_axis_tlast),
        .o_bus    (s2_bus),
        .i_ready  (back_ready)
    );

    // Stages 3-4: differences and second weighting
    rycc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_direction),
        .i_bus    (s2_bus),
        .o_ready  (back_ready),
        .o_bus    (s4_bus),
        .i_ready  (round_ready)
    );

    // Stage 5: round, saturate, hold for the output transfer
    rycc_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_direction),
        .i_bus    (s4_bus),
        .o_ready  (round_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_first  (out_first),
        .o_second (out_second),
        .o_third  (out_third),
        .o_last   (o_m_axis_tlast),
        .i_ready  (i_m_axis_tready)
    );

    // Pack the three samples, first in the lowest bits, pad with zeros
    assign o_m_axis_tdata = TDATA_W'({out_third, out_second, out_first});

endmodule
